/* src/rsi_pkg.sv */
package rsi_pkg;

   // Field widths of the span word and the pixel word.
   localparam int COLOR_W   = 32;
   localparam int LEN_W     = 7;
   localparam int PIXEL_W   = 16;
   localparam int REQ_W     = 200;
   localparam int DEF_MAX_SPAN = 64;

   // Channel ranges in 16.16 form.
   localparam logic [COLOR_W-1:0] RB_MAX = COLOR_W'(31 << 16);
   localparam logic [COLOR_W-1:0] G_MAX  = COLOR_W'(63 << 16);

   // Bit positions of the integer parts that make up an RGB565 pixel.
   localparam int FRAC_W   = 16;
   localparam int RB_BITS  = 5;
   localparam int G_BITS   = 6;

   // The clamped end minus the clamped start fits in a signed 23-bit value.
   localparam int DIFF_W   = 23;
   localparam int MAG_W    = DIFF_W - 1;
   localparam int DCNT_W   = $clog2(MAG_W + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } rsi_state_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } rsi_chan_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dividend;
      logic [LEN_W-1:0]         divisor;
   } rsi_div_req_type;

   typedef struct packed {
      logic               done;
      logic [COLOR_W-1:0] quotient;
   } rsi_div_rsp_type;

endpackage

/* src/rgb565_span_interpolator.sv */
// Channel | Direction | Word contents (lowest bit first)
// req     | in        | red_start, green_start, blue_start, red_delta, green_delta,
//         |           | blue_delta (32 bits each), span_length (7), one zero pad bit
// rsp     | out       | pixel (16 bits); last_pixel travels as rsp_tlast
//
// A span is accepted, then each channel is set up in turn; a channel whose step has to
// be recomputed also passes through the serial divider, which retires one quotient bit
// a cycle (22 bits); then one pixel leaves per cycle while rsp_tready is high.
// A span of length zero produces no word and frees the block after set-up.
// Reset is synchronous and active high; it returns the sequencer to idle.
// A stalled result holds its word; a new span is taken only once the last pixel left.
module rgb565_span_interpolator
   import rsi_pkg::*;
#(
   parameter int MAX_SPAN = DEF_MAX_SPAN
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // red_start [31:0], green_start [63:32], blue_start [95:64], red_delta [127:96],
   // green_delta [159:128], blue_delta [191:160], span_length [198:192], zero [199]
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // pixel [15:0]
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   rsi_state_type       state_ff, state_in;
   rsi_chan_type        chan_ff, chan_in;
   logic [COLOR_W-1:0]  start_ff [3];
   logic [COLOR_W-1:0]  start_in [3];
   logic [COLOR_W-1:0]  delta_ff [3];
   logic [COLOR_W-1:0]  delta_in [3];
   logic [COLOR_W-1:0]  acc_ff [3];
   logic [COLOR_W-1:0]  acc_in [3];
   logic [COLOR_W-1:0]  inc_ff [3];
   logic [COLOR_W-1:0]  inc_in [3];
   logic [LEN_W-1:0]    span_ff, span_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;

   logic                req_fire;
   logic                rsp_fire;
   logic [LEN_W-1:0]    req_len;
   logic [COLOR_W-1:0]  cur_start;
   logic [COLOR_W-1:0]  cur_delta;
   logic [COLOR_W-1:0]  cur_hi;
   logic [COLOR_W-1:0]  clamp_start;
   logic [COLOR_W+LEN_W-1:0] prod;
   logic [COLOR_W-1:0]  end_val;
   logic [COLOR_W-1:0]  clamp_end;
   logic                need_fix;
   logic                last_chan;

   rsi_div_req_type     div_req;
   rsi_div_rsp_type     div_rsp;

   rsi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Over-long spans are cut to the largest supported length.
   assign req_len = (req_tdata[6*COLOR_W +: LEN_W] > LEN_W'(MAX_SPAN))
                  ? LEN_W'(MAX_SPAN) : req_tdata[6*COLOR_W +: LEN_W];

   // Per-channel set-up: clamp the start, form and clamp the end value.
   assign cur_start = start_ff[chan_ff];
   assign cur_delta = delta_ff[chan_ff];
   assign cur_hi    = (chan_ff == CH_GREEN) ? G_MAX : RB_MAX;

   always_comb begin
      if (cur_start[COLOR_W-1]) begin
         clamp_start = '0;
      end else if ($signed(cur_start) > $signed(cur_hi)) begin
         clamp_start = cur_hi;
      end else begin
         clamp_start = cur_start;
      end
   end

   assign prod    = cur_delta * span_ff;
   assign end_val = clamp_start + prod[COLOR_W-1:0];

   always_comb begin
      if (end_val[COLOR_W-1]) begin
         clamp_end = '0;
      end else if ($signed(end_val) > $signed(cur_hi)) begin
         clamp_end = cur_hi;
      end else begin
         clamp_end = end_val;
      end
   end

   assign need_fix  = ((clamp_start != cur_start) || (clamp_end != end_val))
                      && (span_ff != '0);
   assign last_chan = (chan_ff == CH_BLUE);

   // The divider takes the clamped span of values over the pixel count.
   assign div_req.start    = (state_ff == ST_PREP) && need_fix;
   assign div_req.dividend = DIFF_W'(clamp_end[DIFF_W-1:0] - clamp_start[DIFF_W-1:0]);
   assign div_req.divisor  = span_ff;

   // Sequencer: set up each channel in turn, then stream the pixels.
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      inc_in       = inc_ff;
      span_in      = span_ff;
      remaining_in = remaining_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int i = 0; i < 3; i++) begin
                  start_in[i] = req_tdata[i*COLOR_W +: COLOR_W];
                  delta_in[i] = req_tdata[(i+3)*COLOR_W +: COLOR_W];
               end
               span_in  = req_len;
               chan_in  = CH_RED;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            acc_in[chan_ff] = clamp_start;
            inc_in[chan_ff] = cur_delta;
            if (need_fix) begin
               state_in = ST_DIV;
            end else if (last_chan) begin
               remaining_in = span_ff;
               state_in     = (span_ff != '0) ? ST_EMIT : ST_IDLE;
            end else begin
               chan_in = rsi_chan_type'(chan_ff + 2'd1);
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               inc_in[chan_ff] = div_rsp.quotient;
               if (last_chan) begin
                  remaining_in = span_ff;
                  state_in     = ST_EMIT;
               end else begin
                  chan_in  = rsi_chan_type'(chan_ff + 2'd1);
                  state_in = ST_PREP;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = acc_ff[i] + inc_ff[i];
               end
               remaining_in = remaining_ff - LEN_W'(1);
               if (remaining_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CH_RED;
         remaining_ff <= '0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      delta_ff <= delta_in;
      acc_ff   <= acc_in;
      inc_ff   <= inc_in;
      span_ff  <= span_in;
   end

   // Ports: the pixel is built straight from the accumulator registers.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {acc_ff[CH_RED][FRAC_W +: RB_BITS],
                        acc_ff[CH_GREEN][FRAC_W +: G_BITS],
                        acc_ff[CH_BLUE][FRAC_W +: RB_BITS]};
   assign rsp_tlast  = (remaining_ff == LEN_W'(1));

endmodule

/* src/rsi_div.sv */
module rsi_div
   import rsi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rsi_div_req_type div_req,
   output rsi_div_rsp_type div_rsp
);

   logic [LEN_W:0]      rem_ff, rem_in;
   logic [MAG_W-1:0]    quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic [DCNT_W-1:0]   count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [DIFF_W-1:0]   abs_dividend;
   logic [LEN_W:0]      trial;
   logic [LEN_W:0]      divisor_ext;
   logic                fits;
   logic [MAG_W-1:0]    quo_mag;
   logic [DIFF_W-1:0]   quo_signed;

   // Held divisor for the whole division.
   logic [LEN_W-1:0]    divisor_ff, divisor_in;

   // Magnitude of the dividend; the quotient sign is restored at the end.
   assign abs_dividend = div_req.dividend[DIFF_W-1] ? DIFF_W'(-div_req.dividend)
                                                    : DIFF_W'(div_req.dividend);

   // One restoring step per cycle: shift in the next dividend bit and try to subtract.
   assign trial       = {rem_ff[LEN_W-1:0], quo_ff[MAG_W-1]};
   assign divisor_ext = {1'b0, divisor_ff};
   assign fits        = (trial >= divisor_ext);

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      divisor_in = divisor_ff;
      if (div_req.start && !busy_ff) begin
         rem_in     = '0;
         quo_in     = abs_dividend[MAG_W-1:0];
         neg_in     = div_req.dividend[DIFF_W-1];
         count_in   = DCNT_W'(MAG_W);
         busy_in    = 1'b1;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? (trial - divisor_ext) : trial;
         quo_in   = {quo_ff[MAG_W-2:0], fits};
         count_in = count_ff - DCNT_W'(1);
         if (count_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
   end

   // Truncation toward zero: negate the magnitude quotient for a negative dividend.
   assign quo_mag    = quo_ff;
   assign quo_signed = neg_ff ? DIFF_W'(-{1'b0, quo_mag}) : {1'b0, quo_mag};

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = {{(COLOR_W-DIFF_W){quo_signed[DIFF_W-1]}}, quo_signed};

endmodule

/* src/rsi_checker.sv */
module rsi_checker
   import rsi_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [PIXEL_W-1:0] rsp_tdata,
   input logic               rsp_tlast
);

   // A stalled pixel word keeps its value and its end marker.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // The block works on one span at a time: no intake while pixels go out.
   a_one_span: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("span accepted while pixels pending");

   // Right after a span is taken the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // After the final pixel no further pixel follows at once.
   a_end_of_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("pixel after end of span");

   // A span's first pixel appears only after set-up time.
   a_no_instant_pixel: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("pixel without set-up");

endmodule

bind rgb565_span_interpolator rsi_checker u_rsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* verif/rgb565_span_checker.sv */
module rgb565_span_checker
   import rsi_pkg::*;
#(
   parameter int MAX_SPAN = DEF_MAX_SPAN
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   // red_start, green_start, blue_start, red_delta, green_delta, blue_delta, span_length, pad
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   // pixel
   input  logic [PIXEL_W-1:0] rsp_tdata,
   input  logic               rsp_tlast,
   output int                 fail_count,
   output int                 pending,
   output int                 spans_seen,
   output int                 pixels_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_pixel;
   } pixel_word_type;

   // Pixels the block still owes, oldest first.
   pixel_word_type expected_pixels[$];

   // Shadow of the block's shading state.
   logic [COLOR_W-1:0] red_acc, green_acc, blue_acc;
   logic [COLOR_W-1:0] red_step, green_step, blue_step;
   logic [LEN_W-1:0]   pixels_left;

   initial begin
      fail_count = 0;
      pending = 0;
      spans_seen = 0;
      pixels_checked = 0;
      red_acc = '0;
      green_acc = '0;
      blue_acc = '0;
      red_step = '0;
      green_step = '0;
      blue_step = '0;
      pixels_left = '0;
   end

   // Clamps start and end of one channel and recomputes the step when either was clamped.
   function automatic void setup_channel(input logic [COLOR_W-1:0] start_in,
                                         input logic [COLOR_W-1:0] delta_in,
                                         input logic [COLOR_W-1:0] max_val,
                                         input int n,
                                         output logic [COLOR_W-1:0] acc,
                                         output logic [COLOR_W-1:0] step);
      int cs;
      int ce;
      int fin;
      int top_val;
      logic [COLOR_W-1:0] wrapped;
      bit fix;
      top_val = int'(max_val);
      cs = $signed(start_in);
      fix = 1'b0;
      if (cs < 0) begin
         cs = 0;
         fix = 1'b1;
      end else if (cs > top_val) begin
         cs = top_val;
         fix = 1'b1;
      end
      // The end value wraps at 32 bits before it is clamped.
      wrapped = COLOR_W'(cs) + COLOR_W'(n) * delta_in;
      fin = $signed(wrapped);
      ce = fin;
      if (ce < 0) begin
         ce = 0;
      end else if (ce > top_val) begin
         ce = top_val;
      end
      if (ce != fin) begin
         fix = 1'b1;
      end
      step = delta_in;
      if (fix && n != 0) begin
         step = COLOR_W'((ce - cs) / n);
      end
      acc = COLOR_W'(cs);
   endfunction

   // Expands one accepted span into the pixel words it must produce.
   task automatic predict_span(input logic [REQ_W-1:0] span_word);
      int n;
      pixel_word_type w;
      n = int'(span_word[6*COLOR_W +: LEN_W]);
      if (n > MAX_SPAN) begin
         n = MAX_SPAN;
      end
      setup_channel(span_word[0*COLOR_W +: COLOR_W], span_word[3*COLOR_W +: COLOR_W],
                    RB_MAX, n, red_acc, red_step);
      setup_channel(span_word[1*COLOR_W +: COLOR_W], span_word[4*COLOR_W +: COLOR_W],
                    G_MAX, n, green_acc, green_step);
      setup_channel(span_word[2*COLOR_W +: COLOR_W], span_word[5*COLOR_W +: COLOR_W],
                    RB_MAX, n, blue_acc, blue_step);
      pixels_left = LEN_W'(n);
      while (pixels_left != 0) begin
         pixels_left = pixels_left - 1'b1;
         w.pixel = {red_acc[FRAC_W +: RB_BITS], green_acc[FRAC_W +: G_BITS],
                    blue_acc[FRAC_W +: RB_BITS]};
         w.last_pixel = (pixels_left == 0);
         expected_pixels.push_back(w);
         red_acc = red_acc + red_step;
         green_acc = green_acc + green_step;
         blue_acc = blue_acc + blue_step;
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   // Pixel words leave before a new span can enter, so results are matched first.
   always @(posedge clock) begin : watch_channels
      pixel_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               note_failure($sformatf("unexpected pixel word %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel !== rsp_tdata || want.last_pixel !== rsp_tlast) begin
                  note_failure($sformatf("pixel %0d: expected %h last %b, got %h last %b",
                                         pixels_checked, want.pixel, want.last_pixel,
                                         rsp_tdata, rsp_tlast));
               end
               pixels_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_span(req_tdata);
            spans_seen++;
         end
         pending = expected_pixels.size();
      end
   end

endmodule

/* verif/tb_top.sv */
module tb_top
   import rsi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_SPANS = 400;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 150;
   localparam int HOLD_OFF     = 300;
   localparam int HOLD_AT_WORD = 200;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [PIXEL_W-1:0] rsp_tdata;
   logic               rsp_tlast;

   int fail_count;
   int pending;
   int spans_seen;
   int pixels_checked;

   // Span words waiting to be sent, and a few tallies for the summary.
   logic [REQ_W-1:0] span_queue[$];
   int empty_spans;
   int long_spans;

   rgb565_span_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rgb565_span_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending        (pending),
      .spans_seen     (spans_seen),
      .pixels_checked (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Packs one span into a word, red start in the lowest bits.
   task automatic add_span(input logic [COLOR_W-1:0] rs, gs, bs, rd, gd, bd,
                           input logic [LEN_W-1:0] len);
      span_queue.push_back({1'b0, len, bd, gd, rd, bs, gs, rs});
      if (len == 0) begin
         empty_spans++;
      end
      if (len > DEF_MAX_SPAN) begin
         long_spans++;
      end
   endtask

   function automatic logic [COLOR_W-1:0] corner_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return RB_MAX;
         2: return G_MAX;
         3: return RB_MAX + 1;
         4: return '1;
         5: return 32'h8000_0000;
         6: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] corner_length();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 63;
         4: return 64;
         5: return 65;
         6: return 127;
         default: return LEN_W'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] small_step();
      return COLOR_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
   endfunction

   task automatic build_directed();
      // Empty spans, one in range and one with out-of-range start.
      add_span('0, '0, '0, '0, '0, '0, 0);
      add_span(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 0);
      // Single pixels at both ends of the range.
      add_span('0, '0, '0, '0, '0, '0, 1);
      add_span(RB_MAX, G_MAX, RB_MAX, '0, '0, '0, 1);
      // Full ramps at the largest length, then over-long spans that saturate.
      add_span('0, '0, '0, 32'h0000_7800, 32'h0000_F800, 32'h0000_7800, 64);
      add_span('0, '0, '0, 32'h0000_7800, 32'h0000_F800, 32'h0000_7800, 127);
      add_span(RB_MAX, G_MAX, RB_MAX, 32'hFFFF_8800, 32'hFFFF_0800, 32'hFFFF_8800, 65);
      // Negative and oversized starts are clamped.
      add_span(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 8);
      add_span(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, 4);
      // End overshoots the range on either side.
      add_span('0, '0, '0, 32'h0010_0000, 32'h0020_0000, 32'h0010_0000, 16);
      add_span(RB_MAX, G_MAX, RB_MAX, 32'hFFF0_0000, 32'hFFE0_0000, 32'hFFF0_0000, 16);
      // End wraps back into range, so the accumulators wrap on the way.
      add_span(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0400_0000, 32'h0400_0000,
               32'hFC00_0000, 64);
      add_span(32'h0005_8000, 32'h0011_0000, 32'h0000_0000, 32'h0800_0000, 32'hF800_0000,
               32'h0800_0000, 32);
      // Extreme steps.
      add_span(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 2);
      add_span(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 2);
      add_span(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 1);
      add_span('1, '1, '1, '1, '1, '1, 127);
      add_span(RB_MAX + 1, G_MAX + 1, RB_MAX + 1, '1, '1, '1, 63);
      add_span(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0001_0000, 32'hFFFF_0000,
               32'h0000_4000, 2);
   endtask

   task automatic build_random();
      logic [COLOR_W-1:0] rs, gs, bs, rd, gd, bd;
      logic [LEN_W-1:0] len;
      int kind;
      for (int i = 0; i < RANDOM_SPANS; i++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // Well-formed shading: starts in range, modest steps, mostly short.
            rs = $urandom_range(0, int'(RB_MAX));
            gs = $urandom_range(0, int'(G_MAX));
            bs = $urandom_range(0, int'(RB_MAX));
            rd = small_step();
            gd = small_step();
            bd = small_step();
            len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(1, 64))
                                              : LEN_W'($urandom_range(1, 16));
         end else if (kind <= 7) begin
            rs = corner_value();
            gs = corner_value();
            bs = corner_value();
            rd = corner_value();
            gd = corner_value();
            bd = corner_value();
            len = corner_length();
         end else begin
            rs = $urandom();
            gs = $urandom();
            bs = $urandom();
            rd = $urandom();
            gd = $urandom();
            bd = $urandom();
            len = LEN_W'($urandom_range(0, 127));
         end
         add_span(rs, gs, bs, rd, gd, bd, len);
      end
   endtask

   // Result side: random stalls, bursts without stalls, and one long hold-off.
   initial begin : pixel_receiver
      int hold;
      int words_taken;
      int burst_left;
      bit held_off;
      words_taken = 0;
      burst_left = 0;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && words_taken >= HOLD_AT_WORD) begin
            hold = HOLD_OFF;
            held_off = 1'b1;
         end else if (burst_left > 0) begin
            hold = 0;
            burst_left--;
         end else begin
            hold = $urandom_range(0, 6);
            if ($urandom_range(0, 30) == 0) begin
               burst_left = $urandom_range(20, 80);
            end
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         words_taken++;
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   initial begin : quiet_watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", quiet);
            $display("rgb565_span_interpolator test failed");
            $finish;
         end
      end
   end

   // Reset, then send every span with random gaps and occasional gap-free stretches.
   initial begin : span_sender
      int gap;
      int idx;
      empty_spans = 0;
      long_spans = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      build_directed();
      build_random();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idx = 0;
      while (span_queue.size() != 0) begin
         gap = ((idx % 100) < 20) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tdata <= span_queue.pop_front();
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         idx++;
      end
      req_tvalid <= 1'b0;
      // Let the checker book the last span before draining.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d spans and %0d pixels, %0d empty and %0d over-long.",
               spans_seen, pixels_checked, empty_spans, long_spans);
      $display("Stimulus mixed clamped, wrapping and extreme-step spans with stalls on both sides.");
      if (fail_count == 0 && pending == 0) begin
         $display("rgb565_span_interpolator test passed");
      end else begin
         $display("%0d mismatches, %0d pixels still expected", fail_count, pending);
         $display("rgb565_span_interpolator test failed");
      end
      $finish;
   end

endmodule
